FILE: hw/rtl/nearest_unused_point_match_core_assert.svh
// Assertion macros for the nearest unused point match core.
`ifndef NEAREST_UNUSED_POINT_MATCH_CORE_ASSERT_SVH
`define NEAREST_UNUSED_POINT_MATCH_CORE_ASSERT_SVH

// Assert that a condition implies a consequence in the same cycle.
`define NUPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define NUPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/nupm_pkg.sv
// Package: types and constants for the nearest unused point match core.
`default_nettype none
package nupm_pkg;
  localparam int TableDepth = 1024;
  localparam int CoordBits  = 24;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = IdxBits + 1;
  localparam int SqBits     = 2 * (CoordBits + 1);
  localparam int DistBits   = SqBits + 2;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_MATCH  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0] idx_t;
  typedef logic [CntBits-1:0] cnt_t;
  typedef logic [DistBits-1:0] dist_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_MARK, S_OUT
  } state_t;

  // memory write command from controller
  typedef struct packed {
    logic   pt_we;
    logic   mk_we;
    logic   mk_val;
    idx_t   wr_addr;
    point_t pt;
  } mem_wr_t;
endpackage
`default_nettype wire

FILE: hw/rtl/nupm_store.sv
// Point and used-mark memories, one synchronous read port each, epoch-based clear.
`default_nettype none
module nupm_store (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clr,
  input  wire nupm_pkg::mem_wr_t   wr,
  input  wire nupm_pkg::idx_t      rd_addr,
  output nupm_pkg::point_t         rd_pt,
  output logic                     rd_used
);
  import nupm_pkg::*;

  point_t pt_mem [TableDepth];
  logic   mk_mem [TableDepth];
  logic   ep_mem [TableDepth];
  logic   epoch_r;
  logic   mk_q_r;
  logic   ep_q_r;

  // epoch flips on clear; a mark counts only when written in the current epoch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r <= 1'b0;
    end else if (clr) begin
      epoch_r <= ~epoch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.pt_we) begin
      pt_mem[wr.wr_addr] <= wr.pt;
    end
    rd_pt <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.mk_we) begin
      mk_mem[wr.wr_addr] <= wr.mk_val;
      ep_mem[wr.wr_addr] <= epoch_r;
    end
    mk_q_r <= mk_mem[rd_addr];
    ep_q_r <= ep_mem[rd_addr];
  end

  assign rd_used = mk_q_r && (ep_q_r == epoch_r);
endmodule
`default_nettype wire

FILE: hw/rtl/nupm_dist.sv
// Squared distance pipeline: difference, square, sum over three axes.
`default_nettype none
module nupm_dist (
  input  wire logic              clk,
  input  wire logic              in_vld,
  input  wire nupm_pkg::idx_t    in_idx,
  input  wire logic              in_used,
  input  wire nupm_pkg::point_t  qp,
  input  wire nupm_pkg::point_t  ep,
  output logic                   out_vld,
  output nupm_pkg::idx_t         out_idx,
  output nupm_pkg::dist_t        out_dist
);
  import nupm_pkg::*;

  logic signed [CoordBits:0] dx_r, dy_r, dz_r;
  logic [SqBits-1:0] sx_r, sy_r, sz_r;
  logic v1_r, v2_r;
  idx_t i1_r, i2_r;

  // stage 1: differences
  always_ff @(posedge clk) begin
    v1_r <= in_vld && !in_used;
    i1_r <= in_idx;
    dx_r <= {qp.x[CoordBits-1], qp.x} - {ep.x[CoordBits-1], ep.x};
    dy_r <= {qp.y[CoordBits-1], qp.y} - {ep.y[CoordBits-1], ep.y};
    dz_r <= {qp.z[CoordBits-1], qp.z} - {ep.z[CoordBits-1], ep.z};
  end

  // stage 2: squares, operands sign-extended to the full product width
  always_ff @(posedge clk) begin
    v2_r <= v1_r;
    i2_r <= i1_r;
    sx_r <= $unsigned(SqBits'(dx_r) * SqBits'(dx_r));
    sy_r <= $unsigned(SqBits'(dy_r) * SqBits'(dy_r));
    sz_r <= $unsigned(SqBits'(dz_r) * SqBits'(dz_r));
  end

  // stage 3: sum
  always_ff @(posedge clk) begin
    out_vld  <= v2_r;
    out_idx  <= i2_r;
    out_dist <= DistBits'(sx_r) + DistBits'(sy_r) + DistBits'(sz_r);
  end
endmodule
`default_nettype wire

FILE: hw/rtl/nearest_unused_point_match_core.sv
// Top level: command sequencer, scan and best-candidate tracking.
// A match reads one table entry a cycle through the point memory's single read
// port; after the scan the read latency and three distance stages drain, then
// the winner's mark is written. Clear is instant through an epoch bit, so
// there is no clearing pass. One transaction is worked on at a time; a result
// waits in the output register and the next input is taken once it is gone.
`default_nettype none
module nearest_unused_point_match_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // coord_x[23:0], coord_y[47:24], coord_z[71:48]
  input  wire logic [1:0]  in_tuser,  // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // match_index[9:0], zero pad
  output logic [1:0]       out_tuser  // status
);
  import nupm_pkg::*;

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   ptr_r, ptr_nxt;
  point_t q_r;
  logic [1:0] cmd_r;
  logic   found_r, found_nxt, exact_r, exact_nxt;
  idx_t   best_r, best_nxt;
  dist_t  bestd_r, bestd_nxt;
  logic   rvld_r;
  idx_t   ridx_r;
  logic   ovld_r, ovld_nxt;
  logic [1:0] ost_r, ost_nxt;
  idx_t   oidx_r, oidx_nxt;
  logic   clr;
  mem_wr_t wr;
  idx_t   rd_addr;
  point_t rd_pt;
  logic   rd_used;
  logic   dvld;
  idx_t   didx;
  dist_t  ddist;
  logic   in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = 16'(oidx_r);
  assign clr = in_acc && (in_tuser == CMD_CLEAR);
  assign rd_addr = ptr_r[IdxBits-1:0];

  nupm_store u_store (
    .clk, .rst_n, .clr, .wr, .rd_addr, .rd_pt, .rd_used
  );

  nupm_dist u_dist (
    .clk, .in_vld(rvld_r), .in_idx(ridx_r), .in_used(rd_used),
    .qp(q_r), .ep(rd_pt), .out_vld(dvld), .out_idx(didx), .out_dist(ddist)
  );

  // query and command capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
      q_r.x <= in_tdata[CoordBits-1:0];
      q_r.y <= in_tdata[24 +: CoordBits];
      q_r.z <= in_tdata[48 +: CoordBits];
    end
    ridx_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ptr_r   <= '0;
      found_r <= 1'b0;
      exact_r <= 1'b0;
      rvld_r  <= 1'b0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      found_r <= found_nxt;
      exact_r <= exact_nxt;
      rvld_r  <= (state_r == S_SCAN) && (ptr_r < count_r);
      ovld_r  <= ovld_nxt;
    end
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    ost_r   <= ost_nxt;
    oidx_r  <= oidx_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    found_nxt = found_r;
    exact_nxt = exact_r;
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    ovld_nxt  = ovld_r && !out_tready;
    ost_nxt   = ost_r;
    oidx_nxt  = oidx_r;
    wr        = '0;
    wr.pt     = q_r;
    wr.wr_addr = count_r[IdxBits-1:0];

    // candidate compare, exact hit freezes the winner
    if (dvld && !exact_r) begin
      if (ddist == '0) begin
        exact_nxt = 1'b1;
        found_nxt = 1'b1;
        best_nxt  = didx;
      end else if (!found_r || ddist <= bestd_r) begin
        found_nxt = 1'b1;
        best_nxt  = didx;
        bestd_nxt = ddist;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_OUT;
          ost_nxt   = ST_OK;
          oidx_nxt  = '0;
          if (in_tuser == CMD_CLEAR) begin
            count_nxt = '0;
          end else if (in_tuser == CMD_MATCH) begin
            state_nxt = S_SCAN;
            ptr_nxt   = '0;
            found_nxt = 1'b0;
            exact_nxt = 1'b0;
          end
        end else if (cmd_r == CMD_APPEND && state_r == S_IDLE) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ptr_r < count_r) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          ptr_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // read latency plus three distance stages
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == cnt_t'(4)) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (found_r) begin
          wr.mk_we   = 1'b1;
          wr.mk_val  = 1'b1;
          wr.wr_addr = best_r;
          oidx_nxt   = best_r;
        end else begin
          ost_nxt = ST_NOMATCH;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (cmd_r == CMD_APPEND) begin
          if (count_r[IdxBits]) begin
            ost_nxt = ST_FULL;
          end else begin
            wr.pt_we  = 1'b1;
            wr.mk_we  = 1'b1;
            oidx_nxt  = count_r[IdxBits-1:0];
            count_nxt = count_r + 1'b1;
          end
        end
        ovld_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `include "nearest_unused_point_match_core_assert.svh"

  `NUPM_ASSERT_IMPL(a_cnt_bound, 1'b1, count_r <= cnt_t'(TableDepth), "count beyond depth")
  `NUPM_ASSERT_IMPL(a_no_take_busy, in_acc, !ovld_r && state_r == S_IDLE, "input while busy")
  `NUPM_ASSERT_NEXT(a_out_after, state_r == S_OUT, ovld_r, "result not raised")
  `NUPM_ASSERT_IMPL(a_mark_found, wr.mk_we && wr.mk_val, found_r, "mark without winner")
endmodule
`default_nettype wire
